// File: design/bfsa_pkg.sv
// ----------------------------------------------------------------------------
// bfsa_pkg: shared types and constants of the best-fit segment allocator
// Operation and status codes, and the controller/datapath command structs.
// ----------------------------------------------------------------------------
package bfsa_pkg;

  localparam int OP_W     = 2;
  localparam int SIZE_W   = 11;
  localparam int STATUS_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_CHECK   = 2'd2,
    OP_UNUSED  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_NOFIT   = 3'd1,
    ST_INVALID = 3'd2,
    ST_FULL    = 3'd3,
    ST_BADREL  = 3'd4
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic init;       // reload table with one free segment
    logic latch;      // capture the request
    logic scan_clr;   // restart the scan
    logic scan_step;  // look at entry idx, advance
    logic mark_used;  // exact fit: set used at found
    logic split_step; // shift one entry up (toward found)
    logic split_fin;  // write split entries at found
    logic rel_prep;   // set up release merge
    logic rm_step;    // shift one entry down
    logic rel_fin;    // write merged free entry
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic    scan_done;
    logic    found;
    logic    exact;
    logic    full;
    logic    shift_done;
  } stat_t;

endpackage

// File: design/bfsa_if.sv
// ----------------------------------------------------------------------------
// bfsa_req_if / bfsa_rsp_if: valid/ready channels of the allocator
// Request carries the operation, response carries the outcome.
// ----------------------------------------------------------------------------
interface bfsa_req_if #(parameter int ADDR_BITS = 10);
  logic                       valid;
  logic                       ready;
  logic [1:0]                 operation;
  logic [10:0]                request_size;
  logic [ADDR_BITS-1:0]       block_start;
  modport source (output valid, operation, request_size, block_start, input ready);
  modport sink   (input valid, operation, request_size, block_start, output ready);
endinterface

interface bfsa_rsp_if #(parameter int ADDR_BITS = 10);
  logic                 valid;
  logic                 ready;
  logic [2:0]           status;
  logic [ADDR_BITS-1:0] granted_start;
  logic [ADDR_BITS-1:0] granted_end;
  modport source (output valid, status, granted_start, granted_end, input ready);
  modport sink   (input valid, status, granted_start, granted_end, output ready);
endinterface

// File: design/bfsa_datapath.sv
// ----------------------------------------------------------------------------
// bfsa_datapath: segment table, best-fit scan and entry shifting
// Table is held in registers indexed by the sequencer; one entry per cycle.
// ----------------------------------------------------------------------------
module bfsa_datapath #(
  parameter int ADDR_BITS    = 10,
  parameter int MAX_SEGMENTS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  bfsa_pkg::cmd_t                    cmd,
  output bfsa_pkg::stat_t                   st,
  input  logic [ADDR_BITS:0]                mem_size,
  input  logic [1:0]                        req_op,
  input  logic [10:0]                       req_size,
  input  logic [ADDR_BITS-1:0]              req_addr,
  output logic [ADDR_BITS-1:0]              res_start,
  output logic [ADDR_BITS-1:0]              res_end
);

  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int LW = (ADDR_BITS + 1 > bfsa_pkg::SIZE_W) ? ADDR_BITS + 1 : bfsa_pkg::SIZE_W;

  logic [ADDR_BITS-1:0] seg_start [MAX_SEGMENTS];
  logic [ADDR_BITS-1:0] seg_end   [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0] seg_used;
  logic [CW-1:0] count;

  logic [1:0]           op;
  logic [LW-1:0]        size;
  logic [ADDR_BITS-1:0] addr;
  logic [CW-1:0]        idx;     // scan / shift index
  logic                 found;
  logic [IW-1:0]        fidx;
  logic [LW-1:0]        best;
  logic                 m_lo, m_hi;
  logic [ADDR_BITS-1:0] new_start, new_end;
  logic [CW-1:0]        rm_stop;

  // Current entry under the scan
  logic [IW-1:0]        ci;
  logic [IW-1:0]        rm_src;
  logic [LW-1:0]        clen;
  logic                 cfit, cmatch;
  assign ci     = idx[IW-1:0];
  assign rm_src = ci + IW'(m_lo) + IW'(m_hi);
  assign clen   = LW'(seg_end[ci]) - LW'(seg_start[ci]) + LW'(1);
  assign cfit   = !seg_used[ci] && (clen >= size) && (!found || clen < best);
  assign cmatch = seg_used[ci] && (seg_start[ci] == addr);

  logic is_alloc;
  assign is_alloc = (op != 2'(bfsa_pkg::OP_RELEASE));

  assign st.scan_done  = (idx >= count) || (!is_alloc && found);
  assign st.found      = found;
  assign st.exact      = (best == size);
  assign st.full       = (count >= CW'(MAX_SEGMENTS));
  assign st.shift_done = is_alloc ? (idx <= CW'(fidx)) : (idx >= rm_stop);

  assign res_start = seg_start[fidx];
  assign res_end   = seg_end[fidx];

  // Sequence the table
  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      count        <= CW'(1);
      seg_used     <= '0;
      seg_start[0] <= '0;
      seg_end[0]   <= ADDR_BITS'(mem_size - (ADDR_BITS+1)'(1));
    end else begin
      if (cmd.mark_used) seg_used[fidx] <= 1'b1;
      if (cmd.split_step) begin
        seg_start[ci] <= seg_start[ci - IW'(1)];
        seg_end[ci]   <= seg_end[ci - IW'(1)];
        seg_used[ci]  <= seg_used[ci - IW'(1)];
      end
      if (cmd.split_fin) begin
        seg_end[fidx]         <= ADDR_BITS'(LW'(seg_start[fidx]) + size - LW'(1));
        seg_used[fidx]        <= 1'b1;
        seg_start[fidx+IW'(1)] <= ADDR_BITS'(LW'(seg_start[fidx]) + size);
        count                 <= count + CW'(1);
      end
      // Close the gap left by the merged neighbours
      if (cmd.rm_step) begin
        seg_start[ci] <= seg_start[rm_src];
        seg_end[ci]   <= seg_end[rm_src];
        seg_used[ci]  <= seg_used[rm_src];
      end
      if (cmd.rel_fin) begin
        seg_start[fidx] <= new_start;
        seg_end[fidx]   <= new_end;
        seg_used[fidx]  <= 1'b0;
        count           <= count - CW'(m_lo) - CW'(m_hi);
      end
    end
  end

  // Scan and shift bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op   <= req_op;
      size <= LW'(req_size);
      addr <= req_addr;
    end
    if (cmd.scan_clr) begin
      idx   <= '0;
      found <= 1'b0;
      fidx  <= '0;
      best  <= '0;
    end
    if (cmd.scan_step) begin
      // Start split shift at the top entry once the scan ends
      idx <= st.scan_done ? count : idx + CW'(1);
      if (!st.scan_done && (is_alloc ? cfit : (cmatch && !found))) begin
        found <= 1'b1;
        fidx  <= ci;
        best  <= clen;
      end
    end
    if (cmd.split_step) idx <= idx - CW'(1);
    if (cmd.rel_prep) begin
      m_hi      <= (CW'(fidx) + CW'(1) < count) && !seg_used[fidx + IW'(1)];
      m_lo      <= (fidx != '0) && !seg_used[fidx - IW'(1)];
      new_start <= ((fidx != '0) && !seg_used[fidx - IW'(1)]) ?
                   seg_start[fidx - IW'(1)] : seg_start[fidx];
      new_end   <= ((CW'(fidx) + CW'(1) < count) && !seg_used[fidx + IW'(1)]) ?
                   seg_end[fidx + IW'(1)] : seg_end[fidx];
      // Final entry lands at fidx-m_lo; shift entries above down
      if ((fidx != '0) && !seg_used[fidx - IW'(1)]) begin
        fidx <= fidx - IW'(1);
        idx  <= CW'(fidx);
      end else begin
        idx  <= CW'(fidx) + CW'(1);
      end
      rm_stop <= count - CW'(((fidx != '0) && !seg_used[fidx - IW'(1)]) ? 1 : 0)
                 - CW'(((CW'(fidx) + CW'(1) < count) && !seg_used[fidx + IW'(1)]) ? 1 : 0);
    end
    if (cmd.rm_step) idx <= idx + CW'(1);
  end

endmodule

// File: design/bfsa_ctrl.sv
// ----------------------------------------------------------------------------
// bfsa_ctrl: sequencer of the allocator
// Runs scan, split, exact mark or release merge, then presents the result.
// ----------------------------------------------------------------------------
module bfsa_ctrl #(
  parameter int ADDR_BITS = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_op,
  input  logic [10:0]          in_size,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_status,
  output logic [ADDR_BITS-1:0] out_start,
  output logic [ADDR_BITS-1:0] out_end,
  output bfsa_pkg::cmd_t       cmd,
  input  bfsa_pkg::stat_t      st,
  input  logic [ADDR_BITS-1:0] res_start,
  input  logic [ADDR_BITS-1:0] res_end
);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_SPLIT, S_RMERGE, S_RSHIFT} state_t;
  state_t state;
  logic [1:0] op;
  logic grant;

  assign in_ready = (state == S_IDLE) && !out_valid && !grant && !cfg_wr;

  always_comb begin
    cmd           = '0;
    cmd.init      = cfg_wr;
    cmd.latch     = in_valid && in_ready;
    cmd.scan_clr  = in_valid && in_ready;
    cmd.scan_step = (state == S_SCAN);
    cmd.mark_used = (state == S_DECIDE) && (op == 2'(bfsa_pkg::OP_ALLOC)) && st.found
                    && st.exact;
    cmd.split_step = (state == S_SPLIT) && !st.shift_done;
    cmd.split_fin  = (state == S_SPLIT) && st.shift_done;
    cmd.rel_prep   = (state == S_DECIDE) && (op == 2'(bfsa_pkg::OP_RELEASE)) && st.found;
    cmd.rm_step    = (state == S_RSHIFT) && !st.shift_done;
    cmd.rel_fin    = (state == S_RSHIFT) && st.shift_done;
  end

  // Hold state and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      grant     <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (grant) begin
        out_start <= res_start;
        out_end   <= res_end;
        grant     <= 1'b0;
        out_valid <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op <= in_op;
            out_start <= '0;
            out_end   <= '0;
            if (in_op == 2'(bfsa_pkg::OP_UNUSED) ||
                (in_op != 2'(bfsa_pkg::OP_RELEASE) && in_size == '0)) begin
              out_status <= bfsa_pkg::ST_INVALID;
              out_valid  <= 1'b1;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: if (st.scan_done) state <= S_DECIDE;
        S_DECIDE: begin
          state <= S_IDLE;
          if (op == 2'(bfsa_pkg::OP_RELEASE)) begin
            if (st.found) begin
              state <= S_RSHIFT;
              out_status <= bfsa_pkg::ST_OK;
            end else begin
              out_status <= bfsa_pkg::ST_BADREL;
              out_valid  <= 1'b1;
            end
          end else if (!st.found) begin
            out_status <= bfsa_pkg::ST_NOFIT;
            out_valid  <= 1'b1;
          end else if (op == 2'(bfsa_pkg::OP_CHECK)) begin
            out_status <= bfsa_pkg::ST_OK;
            out_valid  <= 1'b1;
          end else if (st.exact) begin
            out_status <= bfsa_pkg::ST_OK;
            grant      <= 1'b1;
          end else if (st.full) begin
            out_status <= bfsa_pkg::ST_FULL;
            out_valid  <= 1'b1;
          end else begin
            out_status <= bfsa_pkg::ST_OK;
            state      <= S_SPLIT;
          end
        end
        S_SPLIT: if (st.shift_done) begin
          state <= S_IDLE;
          grant <= 1'b1;
        end
        S_RSHIFT: if (st.shift_done) begin
          state     <= S_IDLE;
          out_valid <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: design/best_fit_segment_allocator.sv
// ----------------------------------------------------------------------------
// best_fit_segment_allocator: best-fit allocator with coalescing release
// Top level: APB register port, request/response channels, ctrl + datapath.
// ----------------------------------------------------------------------------
// One transaction at a time. The sequencer scans the segment table one entry
// a cycle, then shifts entries for a split or a merge. Register memory_size
// at byte 0 (clamped to 1..2^ADDR_BITS) reloads one free segment at once.
module best_fit_segment_allocator #(
  parameter int ADDR_BITS    = 10,
  parameter int MAX_SEGMENTS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [1:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  bfsa_req_if.sink             req,
  bfsa_rsp_if.source           rsp
);

  localparam logic [ADDR_BITS:0] SIZE_TOP = (ADDR_BITS+1)'(64'd1 << ADDR_BITS);
  localparam logic [ADDR_BITS:0] SIZE_RST = (ADDR_BITS > 10) ? (ADDR_BITS+1)'(1024) : SIZE_TOP;

  logic [ADDR_BITS:0] mem_size;
  logic               cfg_wr;
  logic [10:0]        wv;
  bfsa_pkg::cmd_t     cmd;
  bfsa_pkg::stat_t    st;
  logic [ADDR_BITS-1:0] rs, re;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0);
  assign wv     = pwdata[10:0];
  assign prdata = (paddr == 2'd0) ? 32'(mem_size) : 32'd0;

  // Clamp and hold memory size
  always_ff @(posedge clk) begin
    if (rst) mem_size <= SIZE_RST;
    else if (cfg_wr) begin
      if (wv == '0) mem_size <= (ADDR_BITS+1)'(1);
      else if (64'(wv) > 64'(SIZE_TOP)) mem_size <= SIZE_TOP;
      else mem_size <= (ADDR_BITS+1)'(wv);
    end
  end

  logic [ADDR_BITS:0] mem_size_eff;
  assign mem_size_eff = rst ? SIZE_RST :
                        cfg_wr ? ((wv == '0) ? (ADDR_BITS+1)'(1) :
                        (64'(wv) > 64'(SIZE_TOP)) ? SIZE_TOP :
                        (ADDR_BITS+1)'(wv)) : mem_size;

  bfsa_ctrl #(.ADDR_BITS(ADDR_BITS)) u_ctrl (
    .clk, .rst, .cfg_wr,
    .in_valid(req.valid), .in_ready(req.ready), .in_op(req.operation),
    .in_size(req.request_size),
    .out_valid(rsp.valid), .out_ready(rsp.ready), .out_status(rsp.status),
    .out_start(rsp.granted_start), .out_end(rsp.granted_end),
    .cmd, .st, .res_start(rs), .res_end(re)
  );

  bfsa_datapath #(.ADDR_BITS(ADDR_BITS), .MAX_SEGMENTS(MAX_SEGMENTS)) u_dp (
    .clk, .rst, .cmd, .st, .mem_size(mem_size_eff),
    .req_op(req.operation), .req_size(req.request_size), .req_addr(req.block_start),
    .res_start(rs), .res_end(re)
  );

endmodule

// File: sim/best_fit_segment_allocator_tb.sv
// ----------------------------------------------------------------------------
// best_fit_segment_allocator_tb: self-checking bench for the segment allocator
// Drives a directed table then random allocate/release/check traffic through
// the request channel, predicts each response with a behavioural copy of the
// segment table and compares it field by field; memory_size is reprogrammed
// over APB between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module best_fit_segment_allocator_tb;

  localparam int ABITS   = 10;
  localparam int NSEG    = 32;
  localparam int LIMIT   = 3000000;
  localparam int N_RAND  = 850;
  localparam logic [1:0] REG_MEMORY_SIZE = 2'd0;

  typedef struct packed {
    bfsa_pkg::status_t status;
    logic [ABITS-1:0]  gstart;
    logic [ABITS-1:0]  gend;
  } grant_t;

  typedef struct {
    bfsa_pkg::op_t op;
    logic [10:0]   size;
    logic [9:0]    addr;
    logic          typed;   // expected result given in the row
    grant_t        want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  bfsa_req_if #(.ADDR_BITS(ABITS)) req ();
  bfsa_rsp_if #(.ADDR_BITS(ABITS)) rsp ();

  best_fit_segment_allocator #(.ADDR_BITS(ABITS), .MAX_SEGMENTS(NSEG)) i_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req(req.sink), .rsp(rsp.source)
  );

  // Predictor state: a copy of the segment table
  int unsigned seg_lo [NSEG];
  int unsigned seg_hi [NSEG];
  bit          seg_busy [NSEG];
  int unsigned seg_num;
  int unsigned mem_units;

  grant_t pending_grants [$];
  int     errors = 0;
  int     cycles = 0;
  bit     rx_seen = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    req.valid = 1'b0;
    req.operation = '0;
    req.request_size = '0;
    req.block_start = '0;
    rsp.ready = 1'b0;
  end

  function automatic void table_reload(int unsigned units);
    if (units < 1) units = 1;
    if (units > (1 << ABITS)) units = 1 << ABITS;
    mem_units = units;
    for (int i = 0; i < NSEG; i++) begin
      seg_lo[i] = 0; seg_hi[i] = 0; seg_busy[i] = 1'b0;
    end
    seg_hi[0] = units - 1;
    seg_num = 1;
  endfunction

  function automatic void drop_entry(int unsigned k);
    for (int unsigned i = k; i + 1 < seg_num; i++) begin
      seg_lo[i] = seg_lo[i+1]; seg_hi[i] = seg_hi[i+1]; seg_busy[i] = seg_busy[i+1];
    end
    seg_num--;
  endfunction

  // Work out the response and update the table
  function automatic grant_t allocate_outcome(bfsa_pkg::op_t op, int unsigned size,
                                              int unsigned addr);
    grant_t g;
    int found;
    int unsigned best, len, k;
    g = '{bfsa_pkg::ST_OK, '0, '0};
    found = -1;
    best = 0;
    if (op == bfsa_pkg::OP_ALLOC || op == bfsa_pkg::OP_CHECK) begin
      if (size == 0) begin
        g.status = bfsa_pkg::ST_INVALID;
      end else begin
        for (int unsigned i = 0; i < seg_num; i++) begin
          len = seg_hi[i] - seg_lo[i] + 1;
          if (!seg_busy[i] && len >= size && (found < 0 || len < best)) begin
            best = len; found = i;
          end
        end
        if (found < 0) begin
          g.status = bfsa_pkg::ST_NOFIT;
        end else if (op == bfsa_pkg::OP_ALLOC) begin
          k = found;
          if (best == size) begin
            seg_busy[k] = 1'b1;
            g.gstart = seg_lo[k]; g.gend = seg_hi[k];
          end else if (seg_num >= NSEG) begin
            g.status = bfsa_pkg::ST_FULL;
          end else begin
            for (int unsigned i = seg_num; i > k; i--) begin
              seg_lo[i] = seg_lo[i-1]; seg_hi[i] = seg_hi[i-1];
              seg_busy[i] = seg_busy[i-1];
            end
            seg_num++;
            seg_hi[k] = seg_lo[k] + size - 1;
            seg_busy[k] = 1'b1;
            seg_lo[k+1] = seg_hi[k] + 1;
            g.gstart = seg_lo[k]; g.gend = seg_hi[k];
          end
        end
      end
    end else if (op == bfsa_pkg::OP_RELEASE) begin
      found = -1;
      for (int unsigned i = 0; i < seg_num; i++) begin
        if (found < 0 && seg_lo[i] == addr && seg_busy[i]) found = i;
      end
      if (found < 0) begin
        g.status = bfsa_pkg::ST_BADREL;
      end else begin
        k = found;
        if (k + 1 < seg_num && !seg_busy[k+1]) begin
          seg_hi[k] = seg_hi[k+1];
          drop_entry(k + 1);
        end
        if (k > 0 && !seg_busy[k-1]) begin
          seg_lo[k] = seg_lo[k-1];
          drop_entry(k - 1);
          k--;
        end
        seg_busy[k] = 1'b0;
      end
    end else begin
      g.status = bfsa_pkg::ST_INVALID;
    end
    return g;
  endfunction

  // A random start of a used segment, or any address if none is used
  function automatic int unsigned used_start_pick();
    int unsigned picks [$];
    for (int unsigned i = 0; i < seg_num; i++)
      if (seg_busy[i]) picks.push_back(seg_lo[i]);
    if (picks.size() == 0) return $urandom_range(1023, 0);
    return picks[$urandom_range(picks.size() - 1, 0)];
  endfunction

  task automatic wait_cycles(int n);
    repeat (n) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] a, logic [31:0] d);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Wait for the block to drain, then program memory_size
  task automatic set_memory_size(int unsigned units);
    wait (pending_grants.size() == 0);
    wait_cycles(2 * NSEG + 10);
    apb_write(REG_MEMORY_SIZE, units);
    table_reload(units & 11'h7FF);
  endtask

  // Send one request; a typed row overrides the predicted response
  task automatic send_request(bfsa_pkg::op_t op, int unsigned size, int unsigned addr,
                              bit typed, grant_t want);
    grant_t g;
    repeat ($urandom_range(8, 0)) @(negedge clk);
    @(negedge clk);
    g = allocate_outcome(op, size, addr);
    if (typed && g != want)
      $display("%0t: directed row disagrees with prediction exp=%p pred=%p",
               $time, want, g);
    pending_grants.push_back(typed ? want : g);
    req.valid <= 1'b1;
    req.operation <= op;
    req.request_size <= size[10:0];
    req.block_start <= addr[9:0];
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
    req.valid <= 1'b0;
  endtask

  // Response side: random stalls, compare against the oldest prediction
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (rx_seen || stall == 0) begin
        stall = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 0);
        rx_seen = 1'b0;
      end
      if (stall > 0) begin
        stall--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    grant_t exp, got;
    if (!rst && rsp.valid && rsp.ready) begin
      rx_seen = 1'b1;
      got = '{bfsa_pkg::status_t'(rsp.status), rsp.granted_start, rsp.granted_end};
      if (pending_grants.size() == 0) begin
        $display("%0t: unexpected response %p", $time, got);
        errors++;
      end else begin
        exp = pending_grants.pop_front();
        if (got.status != exp.status || got.gstart != exp.gstart ||
            got.gend != exp.gend) begin
          $display("%0t: mismatch exp status=%0d start=%0d end=%0d",
                   $time, exp.status, exp.gstart, exp.gend);
          $display("%0t:          got status=%0d start=%0d end=%0d",
                   $time, got.status, got.gstart, got.gend);
          errors++;
        end
      end
    end
  end

  // Run-length guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("[best_fit_segment_allocator] ERROR");
      $finish;
    end
  end

  // Stimulus
  initial begin
    row_t plan [$];
    row_t r;
    int unsigned sizes [4];
    int unsigned pick;
    table_reload(1024);
    wait_cycles(2);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes, every operation, each corner case
    plan.push_back('{bfsa_pkg::OP_CHECK,   11'd0,    10'd0,   1, '{bfsa_pkg::ST_INVALID, 0, 0}});
    plan.push_back('{bfsa_pkg::OP_ALLOC,   11'd0,    10'd0,   1, '{bfsa_pkg::ST_INVALID, 0, 0}});
    plan.push_back('{bfsa_pkg::OP_CHECK,   11'd1024, 10'd0,   1, '{bfsa_pkg::ST_OK, 0, 0}});
    plan.push_back('{bfsa_pkg::OP_ALLOC,   11'd1025, 10'd0,   1, '{bfsa_pkg::ST_NOFIT, 0, 0}});
    plan.push_back('{bfsa_pkg::OP_ALLOC,   11'h7FF,  10'd0,   1, '{bfsa_pkg::ST_NOFIT, 0, 0}});
    plan.push_back('{bfsa_pkg::OP_RELEASE, 11'd0,    10'd0,   1, '{bfsa_pkg::ST_BADREL, 0, 0}});
    plan.push_back('{bfsa_pkg::OP_UNUSED,  11'd5,    10'h3FF, 1, '{bfsa_pkg::ST_INVALID, 0, 0}});
    plan.push_back('{bfsa_pkg::OP_ALLOC,   11'd1024, 10'd0,   1, '{bfsa_pkg::ST_OK, 0, 10'd1023}});
    plan.push_back('{bfsa_pkg::OP_CHECK,   11'd1,    10'd0,   1, '{bfsa_pkg::ST_NOFIT, 0, 0}});
    plan.push_back('{bfsa_pkg::OP_RELEASE, 11'd0,    10'd0,   1, '{bfsa_pkg::ST_OK, 0, 0}});
    plan.push_back('{bfsa_pkg::OP_RELEASE, 11'd0,    10'd0,   1, '{bfsa_pkg::ST_BADREL, 0, 0}});
    plan.push_back('{bfsa_pkg::OP_ALLOC,   11'd1,    10'd0,   1, '{bfsa_pkg::ST_OK, 0, 0}});
    plan.push_back('{bfsa_pkg::OP_ALLOC,   11'd100,  10'd0,   0, '{bfsa_pkg::ST_OK, 0, 0}});
    plan.push_back('{bfsa_pkg::OP_ALLOC,   11'd10,   10'd0,   0, '{bfsa_pkg::ST_OK, 0, 0}});
    plan.push_back('{bfsa_pkg::OP_RELEASE, 11'd1,    10'd0,   0, '{bfsa_pkg::ST_OK, 0, 0}});
    plan.push_back('{bfsa_pkg::OP_ALLOC,   11'd50,   10'd0,   0, '{bfsa_pkg::ST_OK, 0, 0}});
    plan.push_back('{bfsa_pkg::OP_RELEASE, 11'd0,    10'd0,   0, '{bfsa_pkg::ST_OK, 0, 0}});
    plan.push_back('{bfsa_pkg::OP_RELEASE, 11'd101,  10'd0,   0, '{bfsa_pkg::ST_OK, 0, 0}});
    plan.push_back('{bfsa_pkg::OP_RELEASE, 11'd0,    10'd51,  0, '{bfsa_pkg::ST_OK, 0, 0}});
    plan.push_back('{bfsa_pkg::OP_RELEASE, 11'd0,    10'd1,   0, '{bfsa_pkg::ST_OK, 0, 0}});
    plan.push_back('{bfsa_pkg::OP_RELEASE, 11'd0,    10'd0,   0, '{bfsa_pkg::ST_OK, 0, 0}});
    foreach (plan[i]) begin
      // release rows carrying a size name the address through that size
      r = plan[i];
      if (r.op == bfsa_pkg::OP_RELEASE && !r.typed && r.size != 0) r.addr = r.size[9:0];
      send_request(r.op, r.size, r.addr, r.typed, r.want);
    end

    // Full table: 34 unit allocations on a 40-unit memory fill all 32 entries
    set_memory_size(40);
    for (int i = 0; i < 34; i++) send_request(bfsa_pkg::OP_ALLOC, 1, 0, 0, '0);
    send_request(bfsa_pkg::OP_CHECK, 2, 0, 0, '0);
    send_request(bfsa_pkg::OP_RELEASE, 0, 10'd5, 0, '0);
    send_request(bfsa_pkg::OP_ALLOC, 3, 0, 0, '0);

    // Random phases over several memory sizes, extremes included
    sizes = '{0, 1, 2047, 1024};
    for (int p = 0; p < 6; p++) begin
      if (p < 4) set_memory_size(sizes[p]);
      else set_memory_size($urandom_range(1023, 2));
      for (int n = 0; n < N_RAND / 6; n++) begin
        pick = $urandom_range(9, 0);
        if (pick < 4)
          send_request(bfsa_pkg::OP_ALLOC,
                       ($urandom_range(7, 0) == 0) ? $urandom_range(2047, 0)
                       : $urandom_range(mem_units / 8 + 1, 1), 0, 0, '0);
        else if (pick < 8)
          send_request(bfsa_pkg::OP_RELEASE, $urandom_range(2047, 0),
                       ($urandom_range(5, 0) == 0) ? $urandom_range(1023, 0)
                       : used_start_pick(), 0, '0);
        else if (pick == 8)
          send_request(bfsa_pkg::OP_CHECK, $urandom_range(2047, 0),
                       $urandom_range(1023, 0), 0, '0);
        else
          send_request(bfsa_pkg::op_t'($urandom_range(3, 0)), $urandom_range(2047, 0),
                       $urandom_range(1023, 0), 0, '0);
        // hold off until every expected response has arrived
        if (n == 40) wait (pending_grants.size() == 0);
      end
    end

    wait (pending_grants.size() == 0);
    wait_cycles(2 * NSEG + 10);
    if (errors == 0) begin
      $display("[best_fit_segment_allocator] OK");
    end else begin
      $display("[best_fit_segment_allocator] ERROR");
    end
    $finish;
  end

endmodule
